>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the SPI buffered controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SBC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SBC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sbc_pkg.sv
// Types, codes and helper functions of the SPI buffered controller.
package sbc_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      ROLE_OFF    = 2'd0,
      ROLE_HOST   = 2'd1,
      ROLE_CLIENT = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      OP_WRITE_DATA  = 3'd0,
      OP_READ_DATA   = 3'd1,
      OP_WRITE_FLAGS = 3'd2,
      OP_FRAME_DONE  = 3'd3,
      OP_SELECT      = 3'd4
   } op_type;

   localparam logic [2:0] REG_PERIPH_EN      = 3'd0;
   localparam logic [2:0] REG_HOST_REQUEST   = 3'd1;
   localparam logic [2:0] REG_BUFFER_MODE    = 3'd2;
   localparam logic [2:0] REG_BUFFER_WRITE   = 3'd3;
   localparam logic [2:0] REG_SELECT_DISABLE = 3'd4;
   localparam logic [2:0] REG_INT_ENABLES    = 3'd5;

   localparam logic [6:0] FLAG_IF     = 7'h01;
   localparam logic [6:0] FLAG_WRCOL  = 7'h02;
   localparam logic [6:0] FLAG_RXCIF  = 7'h04;
   localparam logic [6:0] FLAG_TXCIF  = 7'h08;
   localparam logic [6:0] FLAG_DREIF  = 7'h10;
   localparam logic [6:0] FLAG_SSIF   = 7'h20;
   localparam logic [6:0] FLAG_BUFOVF = 7'h40;
   localparam logic [6:0] NORM_FLAGS  = 7'h03;
   localparam logic [6:0] BUF_FLAGS   = 7'h7C;
   localparam logic [6:0] BUF_CLEARABLE = 7'h6C;
   localparam logic [4:0] NORM_ENABLES = 5'h01;
   localparam logic [4:0] BUF_ENABLES  = 5'h1E;

   typedef struct packed {
      logic       enable;
      logic       host_request;
      logic       buffer_mode;
      logic       buffer_write;
      logic       select_disable;
      logic [4:0] int_enables;
   } cfg_type;

   typedef struct packed {
      mode_type   mode;
      logic       active;
      logic       selected;
      logic [7:0] tx_hold;
      logic       tx_hold_valid;
      logic [6:0] flags;
      logic [6:0] deferred;
      logic [7:0] data_reg;
   } state_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] value;
      logic       select_level;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [6:0] flags;
      logic       irq;
      logic       shift_load;
      logic [7:0] shift_byte;
      logic       transfer_active;
      logic [1:0] current_mode;
   } rsp_type;

   typedef struct packed {
      mode_type   mode;
      logic       active;
      logic       host_clear;
      logic [6:0] flag_set;
   } sel_result_type;

   function automatic logic [6:0] valid_flags(logic buffer_mode);
      return buffer_mode ? BUF_FLAGS : NORM_FLAGS;
   endfunction

   // Reaction of the current mode to the select line level.
   function automatic sel_result_type select_f(mode_type mode, logic sel, logic act,
                                               logic sel_dis, logic buffer_mode);
      sel_result_type r;
      r.mode       = mode;
      r.active     = act;
      r.host_clear = 1'b0;
      r.flag_set   = '0;
      case (mode)
         ROLE_HOST: begin
            if (sel && !sel_dis) begin
               r.mode       = ROLE_CLIENT;
               r.active     = 1'b1;
               r.host_clear = 1'b1;
               r.flag_set   = buffer_mode ? FLAG_SSIF : FLAG_IF;
            end
         end
         ROLE_CLIENT: begin
            r.active = sel;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/sbc_req_if.sv
// Request channel interface carrying one controller event per transfer.
interface sbc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [7:0] value;
   logic       select_level;

   modport source (output valid, operation, value, select_level, input ready);
   modport sink (input valid, operation, value, select_level, output ready);
endinterface

>>> hw/rtl/sbc_rsp_if.sv
// Response channel interface carrying one controller result per transfer.
interface sbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [6:0] flags;
   logic       irq;
   logic       shift_load;
   logic [7:0] shift_byte;
   logic       transfer_active;
   logic [1:0] current_mode;

   modport source (output valid, read_data, flags, irq, shift_load, shift_byte,
                   transfer_active, current_mode, input ready);
   modport sink (input valid, read_data, flags, irq, shift_load, shift_byte,
                 transfer_active, current_mode, output ready);
endinterface

>>> hw/rtl/sbc_step.sv
// Next-state and result logic for one controller event.
module sbc_step #(
   parameter int RX_DEPTH = 3
) (
   input  sbc_pkg::cfg_type   cfg,
   input  sbc_pkg::state_type st,
   input  sbc_pkg::item_type  item,
   input  logic [$clog2(RX_DEPTH+1)-1:0] rx_count,
   input  logic [7:0]         rx_queue [RX_DEPTH],
   output sbc_pkg::state_type st_next,
   output logic [$clog2(RX_DEPTH+1)-1:0] rx_count_next,
   output logic [7:0]         rx_queue_next [RX_DEPTH],
   output logic               host_clear,
   output sbc_pkg::rsp_type   rsp
);
   import sbc_pkg::*;

   localparam int CW = $clog2(RX_DEPTH + 1);
   localparam int IW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(RX_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic [6:0]     fmask;
   logic [7:0]     rd;
   logic           load;
   logic [7:0]     load_byte;
   logic           hold;
   logic           pushed;
   sel_result_type sel_r;

   always_comb begin
      st_next       = st;
      rx_count_next = rx_count;
      rx_queue_next = rx_queue;
      host_clear    = 1'b0;
      rd            = '0;
      load          = 1'b0;
      load_byte     = '0;
      hold          = 1'b0;
      pushed        = 1'b0;
      fmask         = valid_flags(cfg.buffer_mode);
      sel_r         = '0;
      case (item.operation)
         OP_WRITE_DATA: begin
            st_next.data_reg = item.value;
            if (cfg.enable) begin
               if (cfg.buffer_mode || !st.active) begin
                  if (cfg.buffer_mode && rx_count >= DEPTH_C) begin
                     st_next.flags = st_next.flags | (FLAG_BUFOVF & fmask);
                  end
                  hold = cfg.buffer_mode && (st.mode == ROLE_CLIENT) && !cfg.buffer_write;
                  if (st.active || hold) begin
                     st_next.tx_hold       = item.value;
                     st_next.tx_hold_valid = 1'b1;
                  end else begin
                     load      = 1'b1;
                     load_byte = item.value;
                  end
                  if ((st.mode == ROLE_HOST) && !st.active) begin
                     st_next.active = 1'b1;
                     if (rx_count >= DEPTH_C) begin
                        rx_count_next = DEPTH_C - ONE_C;
                     end
                  end
                  if (cfg.buffer_mode && st_next.tx_hold_valid) begin
                     st_next.flags = st_next.flags & ~(FLAG_DREIF & fmask);
                  end
               end else begin
                  st_next.flags = st_next.flags | (FLAG_WRCOL & fmask);
               end
            end
         end
         OP_READ_DATA: begin
            rd = st.data_reg;
            if (rx_count != '0) begin
               rd = rx_queue[0];
               for (int i = 0; i < RX_DEPTH - 1; i++) begin
                  rx_queue_next[i] = rx_queue[i+1];
               end
               rx_count_next = rx_count - ONE_C;
            end
            if (cfg.buffer_mode) begin
               st_next.flags = st_next.flags & ~(FLAG_BUFOVF & fmask);
               if (rx_count_next == '0) begin
                  st_next.flags = st_next.flags & ~(FLAG_RXCIF & fmask);
               end
            end
            st_next.flags    = st_next.flags & ~(st.deferred & fmask);
            st_next.deferred = '0;
         end
         OP_WRITE_FLAGS: begin
            if (cfg.buffer_mode) begin
               st_next.flags = st_next.flags & ~(item.value[6:0] & BUF_CLEARABLE & fmask);
            end
            st_next.deferred = st.deferred | (item.value[6:0] & fmask);
         end
         OP_FRAME_DONE: begin
            if (st.active) begin
               pushed = rx_count < DEPTH_C;
               if (pushed) begin
                  rx_queue_next[rx_count[IW-1:0]] = item.value;
                  rx_count_next = rx_count + ONE_C;
               end
               if (cfg.buffer_mode) begin
                  st_next.flags = st_next.flags | ((FLAG_RXCIF | FLAG_DREIF) & fmask);
                  if (!st.tx_hold_valid) begin
                     st_next.flags = st_next.flags | (FLAG_TXCIF & fmask);
                  end
               end else begin
                  st_next.flags = st_next.flags | (FLAG_IF & fmask);
                  if (rx_count_next > ONE_C) begin
                     rx_queue_next[0] = pushed ? item.value : rx_queue[RX_DEPTH-1];
                     rx_count_next    = ONE_C;
                  end
               end
               if (st.tx_hold_valid) begin
                  load                  = 1'b1;
                  load_byte             = st.tx_hold;
                  st_next.tx_hold_valid = 1'b0;
               end else if (st.mode != ROLE_CLIENT) begin
                  st_next.active = 1'b0;
               end
            end
         end
         OP_SELECT: begin
            st_next.selected = !item.select_level;
            sel_r = select_f(st.mode, !item.select_level, st.active, cfg.select_disable,
                             cfg.buffer_mode);
            st_next.mode   = sel_r.mode;
            st_next.active = sel_r.active;
            host_clear     = sel_r.host_clear;
            st_next.flags  = st_next.flags | (sel_r.flag_set & fmask);
         end
         default: begin
         end
      endcase

      rsp.read_data       = rd;
      rsp.flags           = st_next.flags;
      rsp.irq             = cfg.buffer_mode ? |(cfg.int_enables[4:1] & st_next.flags[5:2])
                                            : (cfg.int_enables[0] & st_next.flags[0]);
      rsp.shift_load      = load;
      rsp.shift_byte      = load_byte;
      rsp.transfer_active = st_next.active;
      rsp.current_mode    = st_next.mode;
   end

endmodule

>>> hw/rtl/spi_buffered_controller_core.sv
// Top level of the SPI buffered controller: registers, channels and APB port.
//
// Each request transfer is one controller event and produces exactly one
// response transfer. An event is captured in an input register, evaluated
// against the controller state once the response register is free or being
// taken, and written to the response register. A new request is taken every
// cycle while the response side keeps up. The controller state, the receive
// queue (a shift register of RX_DEPTH bytes read at its head) and the
// response register all update at the edge that evaluates the event.
// Register writes over the APB port take effect at the access edge and are
// expected only while no event is in flight.
`include "assert_macros.svh"

module spi_buffered_controller_core #(
   parameter int RX_DEPTH = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   sbc_req_if.sink                        req_ch,
   sbc_rsp_if.source                      rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sbc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sbc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sbc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import sbc_pkg::*;

   localparam int CW = $clog2(RX_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(RX_DEPTH);

   logic           in_valid_ff;
   item_type       in_item_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;
   cfg_type        cfg_ff, cfg_in;
   state_type      state_ff, state_in;
   logic [CW-1:0]  rx_count_ff, rx_count_in;
   logic [7:0]     rx_queue_ff [RX_DEPTH];
   logic [7:0]     rx_queue_in [RX_DEPTH];

   state_type      step_state;
   logic [CW-1:0]  step_count;
   logic [7:0]     step_queue [RX_DEPTH];
   logic           step_host_clear;
   rsp_type        step_rsp;

   logic           advance;
   logic           cfg_wr;
   logic [2:0]     cfg_idx;
   mode_type       target_mode;
   sel_result_type cfg_sel;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign cfg_wr       = psel && penable && pwrite;
   assign cfg_idx      = paddr[4:2];
   assign pready       = 1'b1;

   sbc_step #(
      .RX_DEPTH(RX_DEPTH)
   ) u_step (
      .cfg          (cfg_ff),
      .st           (state_ff),
      .item         (in_item_ff),
      .rx_count     (rx_count_ff),
      .rx_queue     (rx_queue_ff),
      .st_next      (step_state),
      .rx_count_next(step_count),
      .rx_queue_next(step_queue),
      .host_clear   (step_host_clear),
      .rsp          (step_rsp)
   );

   always_comb begin
      cfg_in      = cfg_ff;
      state_in    = state_ff;
      rx_count_in = rx_count_ff;
      rx_queue_in = rx_queue_ff;
      target_mode = ROLE_OFF;
      cfg_sel     = '0;
      if (cfg_wr) begin
         case (cfg_idx)
            REG_PERIPH_EN, REG_HOST_REQUEST: begin
               if (cfg_idx == REG_PERIPH_EN) begin
                  cfg_in.enable = pwdata[0];
               end else begin
                  cfg_in.host_request = pwdata[0];
               end
               target_mode = !cfg_in.enable ? ROLE_OFF
                           : (cfg_in.host_request ? ROLE_HOST : ROLE_CLIENT);
               if (target_mode != state_ff.mode) begin
                  cfg_sel = select_f(target_mode, state_ff.selected, state_ff.active,
                                     cfg_ff.select_disable, cfg_ff.buffer_mode);
                  state_in.mode   = cfg_sel.mode;
                  state_in.active = cfg_sel.active;
                  state_in.flags  = state_ff.flags
                                  | (cfg_sel.flag_set & valid_flags(cfg_ff.buffer_mode));
                  if (cfg_sel.host_clear) begin
                     cfg_in.host_request = 1'b0;
                  end
               end
            end
            REG_BUFFER_MODE: begin
               cfg_in.buffer_mode = pwdata[0];
               cfg_in.int_enables = cfg_ff.int_enables
                                  & (pwdata[0] ? BUF_ENABLES : NORM_ENABLES);
               state_in.flags     = state_ff.flags & valid_flags(pwdata[0]);
            end
            REG_BUFFER_WRITE: begin
               cfg_in.buffer_write = pwdata[0];
            end
            REG_SELECT_DISABLE: begin
               cfg_in.select_disable = pwdata[0];
            end
            REG_INT_ENABLES: begin
               cfg_in.int_enables = pwdata[4:0];
            end
            default: begin
            end
         endcase
      end else if (advance) begin
         state_in    = step_state;
         rx_count_in = step_count;
         rx_queue_in = step_queue;
         if (step_host_clear) begin
            cfg_in.host_request = 1'b0;
         end
      end
   end

   always_comb begin
      prdata = '0;
      case (cfg_idx)
         REG_PERIPH_EN:      prdata[0]   = cfg_ff.enable;
         REG_HOST_REQUEST:   prdata[0]   = cfg_ff.host_request;
         REG_BUFFER_MODE:    prdata[0]   = cfg_ff.buffer_mode;
         REG_BUFFER_WRITE:   prdata[0]   = cfg_ff.buffer_write;
         REG_SELECT_DISABLE: prdata[0]   = cfg_ff.select_disable;
         REG_INT_ENABLES:    prdata[4:0] = cfg_ff.int_enables;
         default:            prdata      = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cfg_ff         <= '0;
         state_ff       <= '{mode: ROLE_OFF, active: 1'b0, selected: 1'b0,
                             tx_hold: 8'h00, tx_hold_valid: 1'b0, flags: FLAG_DREIF,
                             deferred: 7'h00, data_reg: 8'h00};
         rx_count_ff    <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         cfg_ff      <= cfg_in;
         state_ff    <= state_in;
         rx_count_ff <= rx_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff <= {req_ch.operation, req_ch.value, req_ch.select_level};
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
      rx_queue_ff <= rx_queue_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.read_data       = rsp_ff.read_data;
   assign rsp_ch.flags           = rsp_ff.flags;
   assign rsp_ch.irq             = rsp_ff.irq;
   assign rsp_ch.shift_load      = rsp_ff.shift_load;
   assign rsp_ch.shift_byte      = rsp_ff.shift_byte;
   assign rsp_ch.transfer_active = rsp_ff.transfer_active;
   assign rsp_ch.current_mode    = rsp_ff.current_mode;

   `SBC_ASSERT_IMP(a_rx_count_bound, 1'b1, rx_count_ff <= DEPTH_C, "receive count beyond depth")
   `SBC_ASSERT_NXT(a_norm_keeps_newest, advance && !cfg_wr && (in_item_ff.operation == OP_FRAME_DONE) && !cfg_ff.buffer_mode && state_ff.active, rx_count_ff == CW'(1), "normal frame left other than one byte")
   `SBC_ASSERT_NXT(a_req_captured, req_ch.valid && req_ch.ready, in_valid_ff, "accepted transfer not held in input register")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the SPI buffered controller core.
module testbench;
   import sbc_pkg::*;

   localparam int RX_DEPTH = 3;
   localparam int RANDOM_PHASES = 11;
   localparam int EVENTS_PER_PHASE = 52;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   sbc_req_if req_ch();
   sbc_rsp_if rsp_ch();

   spi_buffered_controller_core #(.RX_DEPTH(RX_DEPTH)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   item_type pending_events[$];
   rsp_type expected_results[$];
   item_type on_bus;
   bit idle_on = 1'b1;
   int send_gap = 0;
   int hold_off = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;

   // Shadow of the controller: configuration, state and receive queue.
   cfg_type shadow_cfg;
   state_type ctl_state;
   logic [7:0] rx_fifo[$];
   logic shift_loaded;
   logic [7:0] shift_value;

   function automatic logic [6:0] mode_valid_flags();
      return shadow_cfg.buffer_mode ? BUF_FLAGS : NORM_FLAGS;
   endfunction

   function automatic void raise_flags(logic [6:0] m);
      ctl_state.flags = ctl_state.flags | (m & mode_valid_flags());
   endfunction

   function automatic void drop_flags(logic [6:0] m);
      ctl_state.flags = ctl_state.flags & ~(m & mode_valid_flags());
   endfunction

   function automatic void select_react();
      case (ctl_state.mode)
         ROLE_HOST: begin
            if (ctl_state.selected && !shadow_cfg.select_disable) begin
               shadow_cfg.host_request = 1'b0;
               ctl_state.mode = ROLE_CLIENT;
               ctl_state.active = ctl_state.selected;
               raise_flags(shadow_cfg.buffer_mode ? FLAG_SSIF : FLAG_IF);
            end
         end
         ROLE_CLIENT: begin
            ctl_state.active = ctl_state.selected;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void switch_mode(mode_type m);
      if (m != ctl_state.mode) begin
         ctl_state.mode = m;
         select_react();
      end
   endfunction

   function automatic void send_byte(logic [7:0] b, logic hold);
      if (ctl_state.active || hold) begin
         ctl_state.tx_hold = b;
         ctl_state.tx_hold_valid = 1'b1;
      end else begin
         shift_loaded = 1'b1;
         shift_value = b;
      end
      if (ctl_state.mode == ROLE_HOST && !ctl_state.active) begin
         ctl_state.active = 1'b1;
         if (rx_fifo.size() >= RX_DEPTH) rx_fifo.delete(rx_fifo.size() - 1);
      end
   endfunction

   function automatic void reset_shadow();
      shadow_cfg = '0;
      ctl_state = '0;
      ctl_state.mode = ROLE_OFF;
      ctl_state.flags = FLAG_DREIF;
      rx_fifo.delete();
   endfunction

   function automatic void shadow_register_write(logic [2:0] index, logic [4:0] data);
      case (index)
         REG_PERIPH_EN: shadow_cfg.enable = data[0];
         REG_HOST_REQUEST: shadow_cfg.host_request = data[0];
         REG_BUFFER_MODE: begin
            shadow_cfg.buffer_mode = data[0];
            shadow_cfg.int_enables &= data[0] ? BUF_ENABLES : NORM_ENABLES;
            ctl_state.flags &= mode_valid_flags();
         end
         REG_BUFFER_WRITE: shadow_cfg.buffer_write = data[0];
         REG_SELECT_DISABLE: shadow_cfg.select_disable = data[0];
         REG_INT_ENABLES: shadow_cfg.int_enables = data;
         default: begin
         end
      endcase
      if (index == REG_PERIPH_EN || index == REG_HOST_REQUEST) begin
         if (!shadow_cfg.enable) switch_mode(ROLE_OFF);
         else if (shadow_cfg.host_request) switch_mode(ROLE_HOST);
         else switch_mode(ROLE_CLIENT);
      end
   endfunction

   function automatic rsp_type predict_result(item_type it);
      rsp_type r;
      logic [7:0] read_byte;
      read_byte = 8'h00;
      shift_loaded = 1'b0;
      shift_value = 8'h00;
      case (it.operation)
         OP_WRITE_DATA: begin
            ctl_state.data_reg = it.value;
            if (shadow_cfg.enable) begin
               if (shadow_cfg.buffer_mode) begin
                  if (rx_fifo.size() >= RX_DEPTH) raise_flags(FLAG_BUFOVF);
                  send_byte(it.value,
                            ctl_state.mode == ROLE_CLIENT && !shadow_cfg.buffer_write);
                  if (ctl_state.tx_hold_valid) drop_flags(FLAG_DREIF);
               end else if (ctl_state.active) begin
                  raise_flags(FLAG_WRCOL);
               end else begin
                  send_byte(it.value, 1'b0);
               end
            end
         end
         OP_READ_DATA: begin
            read_byte = ctl_state.data_reg;
            if (rx_fifo.size() != 0) begin
               read_byte = rx_fifo[0];
               rx_fifo.delete(0);
            end
            if (shadow_cfg.buffer_mode) begin
               drop_flags(FLAG_BUFOVF);
               if (rx_fifo.size() == 0) drop_flags(FLAG_RXCIF);
            end
            drop_flags(ctl_state.deferred);
            ctl_state.deferred = '0;
         end
         OP_WRITE_FLAGS: begin
            if (shadow_cfg.buffer_mode) drop_flags(it.value[6:0] & BUF_CLEARABLE);
            ctl_state.deferred |= it.value[6:0] & mode_valid_flags();
         end
         OP_FRAME_DONE: begin
            if (ctl_state.active) begin
               if (rx_fifo.size() < RX_DEPTH) rx_fifo.insert(rx_fifo.size(), it.value);
               if (shadow_cfg.buffer_mode) begin
                  raise_flags(FLAG_RXCIF | FLAG_DREIF);
                  if (!ctl_state.tx_hold_valid) raise_flags(FLAG_TXCIF);
               end else begin
                  raise_flags(FLAG_IF);
                  while (rx_fifo.size() > 1) rx_fifo.delete(0);
               end
               if (ctl_state.tx_hold_valid) begin
                  shift_loaded = 1'b1;
                  shift_value = ctl_state.tx_hold;
                  ctl_state.tx_hold_valid = 1'b0;
               end else if (ctl_state.mode != ROLE_CLIENT) begin
                  ctl_state.active = 1'b0;
               end
            end
         end
         OP_SELECT: begin
            ctl_state.selected = !it.select_level;
            select_react();
         end
         default: begin
         end
      endcase
      r.read_data = read_byte;
      r.flags = ctl_state.flags;
      if (shadow_cfg.buffer_mode) r.irq = |(shadow_cfg.int_enables[4:1] & ctl_state.flags[5:2]);
      else r.irq = shadow_cfg.int_enables[0] & ctl_state.flags[0];
      r.shift_load = shift_loaded;
      r.shift_byte = shift_loaded ? shift_value : 8'h00;
      r.transfer_active = ctl_state.active;
      r.current_mode = ctl_state.mode;
      return r;
   endfunction

   function automatic void queue_event(logic [2:0] op, logic [7:0] value, logic level);
      item_type it;
      it.operation = op;
      it.value = value;
      it.select_level = level;
      pending_events.insert(pending_events.size(), it);
   endfunction

   function automatic void queue_random_event();
      int pick;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 30) op = OP_WRITE_DATA;
      else if (pick < 60) op = OP_FRAME_DONE;
      else if (pick < 75) op = OP_READ_DATA;
      else if (pick < 86) op = OP_WRITE_FLAGS;
      else if (pick < 94) op = OP_SELECT;
      else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      queue_event(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endfunction

   function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic csr_write(logic [2:0] index, logic [4:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= CSR_DATA_W'(data);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      shadow_register_write(index, data);
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_ch.valid || expected_results.size() != 0);
   endtask

   task automatic apply_phase_settings(int k);
      logic en, host, bm, bw, sd;
      logic [4:0] ie;
      if (k == 0) begin
         {en, host, bm, bw, sd} = 5'b11111;
         ie = 5'h1F;
      end else if (k == 1) begin
         {en, host, bm, bw, sd} = 5'b10000;
         ie = 5'h00;
      end else begin
         en = ($urandom_range(0, 7) != 0);
         host = 1'($urandom_range(0, 1));
         bm = 1'($urandom_range(0, 1));
         bw = 1'($urandom_range(0, 1));
         sd = 1'($urandom_range(0, 1));
         ie = 5'($urandom_range(0, 31));
      end
      csr_write(REG_BUFFER_MODE, 5'(bm));
      csr_write(REG_BUFFER_WRITE, 5'(bw));
      csr_write(REG_SELECT_DISABLE, 5'(sd));
      csr_write(REG_INT_ENABLES, ie);
      csr_write(REG_HOST_REQUEST, 5'(host));
      csr_write(REG_PERIPH_EN, 5'(en));
      // A host starts deselected and a client starts selected.
      queue_event(OP_SELECT, 8'($urandom_range(0, 255)), host);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.operation <= '0;
         req_ch.value <= '0;
         req_ch.select_level <= 1'b0;
         send_gap = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) expected_results.insert(expected_results.size(), predict_result(on_bus));
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_events.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 10);
            req_ch.valid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            on_bus = pending_events[0];
            pending_events.delete(0);
            req_ch.valid <= 1'b1;
            req_ch.operation <= on_bus.operation;
            req_ch.value <= on_bus.value;
            req_ch.select_level <= on_bus.select_level;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_off = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result transfer with no expectation pending", $time);
               mismatch_count++;
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               compare_field("read_data", want.read_data, rsp_ch.read_data);
               compare_field("flags", 8'(want.flags), 8'(rsp_ch.flags));
               compare_field("irq", 8'(want.irq), 8'(rsp_ch.irq));
               compare_field("shift_load", 8'(want.shift_load), 8'(rsp_ch.shift_load));
               compare_field("shift_byte", want.shift_byte, rsp_ch.shift_byte);
               compare_field("transfer_active", 8'(want.transfer_active),
                             8'(rsp_ch.transfer_active));
               compare_field("current_mode", 8'(want.current_mode), 8'(rsp_ch.current_mode));
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold_off = $urandom_range(0, 10);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (psel && penable)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset_shadow();
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Disabled after reset: no event starts a transfer or loads the shift register.
      queue_event(OP_WRITE_DATA, 8'h00, 1'b0);
      queue_event(OP_WRITE_DATA, 8'hFF, 1'b1);
      queue_event(OP_READ_DATA, 8'h00, 1'b0);
      queue_event(OP_WRITE_FLAGS, 8'hFF, 1'b0);
      queue_event(OP_FRAME_DONE, 8'h81, 1'b0);
      queue_event(OP_SELECT, 8'h00, 1'b0);
      queue_event(OP_SELECT, 8'h00, 1'b1);
      queue_event(OP_UNUSED_LO, 8'hAA, 1'b1);
      queue_event(OP_UNUSED_HI, 8'h55, 1'b0);
      wait_quiet();

      // Normal host: start, write collision, frame end, deferred clear, host lost.
      csr_write(REG_BUFFER_MODE, 5'd0);
      csr_write(REG_INT_ENABLES, NORM_ENABLES);
      csr_write(REG_HOST_REQUEST, 5'd1);
      csr_write(REG_PERIPH_EN, 5'd1);
      queue_event(OP_WRITE_DATA, 8'hA5, 1'b0);
      queue_event(OP_WRITE_DATA, 8'h5A, 1'b0);
      queue_event(OP_FRAME_DONE, 8'h3C, 1'b0);
      queue_event(OP_READ_DATA, 8'h00, 1'b0);
      queue_event(OP_WRITE_FLAGS, 8'h03, 1'b0);
      queue_event(OP_READ_DATA, 8'h00, 1'b0);
      queue_event(OP_SELECT, 8'h00, 1'b0);
      queue_event(OP_SELECT, 8'h00, 1'b1);
      wait_quiet();

      // Buffered client: held byte, queue fill, overflow, immediate flag clears.
      csr_write(REG_BUFFER_MODE, 5'd1);
      csr_write(REG_BUFFER_WRITE, 5'd0);
      csr_write(REG_INT_ENABLES, BUF_ENABLES);
      queue_event(OP_SELECT, 8'h00, 1'b0);
      queue_event(OP_WRITE_DATA, 8'h11, 1'b0);
      queue_event(OP_FRAME_DONE, 8'h22, 1'b0);
      queue_event(OP_FRAME_DONE, 8'h33, 1'b0);
      queue_event(OP_FRAME_DONE, 8'h44, 1'b0);
      queue_event(OP_WRITE_DATA, 8'h55, 1'b0);
      queue_event(OP_WRITE_FLAGS, 8'hFF, 1'b0);
      queue_event(OP_READ_DATA, 8'h00, 1'b0);
      queue_event(OP_SELECT, 8'h00, 1'b1);
      wait_quiet();

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         idle_on = (k != RANDOM_PHASES - 1) && (k % 3 != 2);
         apply_phase_settings(k);
         repeat (EVENTS_PER_PHASE) queue_random_event();
         wait_quiet();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
